### rtl/ile_pkg.sv
// Shared types and constants for the indexed list engine.
package ile_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ACTION_W = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_READ       = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_APPEND     = 3'd2,
        ACT_INSERT     = 3'd3,
        ACT_DELETE     = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT_UP,
        S_SHIFT_DN,
        S_PLACE,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } mem_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        status_t                  status;
        logic [CNT_W-1:0]         entry_count;
    } result_t;

endpackage

### rtl/ile_if.sv
// Request and response channel interfaces for the indexed list engine.
interface ile_in_if;
    logic                              valid;
    logic                              ready;
    logic [ile_pkg::ACTION_W-1:0]      action;
    logic [ile_pkg::POS_W-1:0]         position;
    logic signed [ile_pkg::DATA_W-1:0] value_in;

    modport source (output valid, output action, output position, output value_in,
                    input ready);
    modport sink (input valid, input action, input position, input value_in,
                  output ready);
endinterface

interface ile_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ile_pkg::DATA_W-1:0] read_value;
    logic [ile_pkg::STATUS_W-1:0]      status;
    logic [ile_pkg::CNT_W-1:0]         entry_count;

    modport source (output valid, output read_value, output status, output entry_count,
                    input ready);
    modport sink (input valid, input read_value, input status, input entry_count,
                  output ready);
endinterface

### rtl/ile_store.sv
// Value store: one write port, one registered read port.
module ile_store (
    input  logic                              clk,
    input  ile_pkg::mem_req_t                 mem_req,
    output logic signed [ile_pkg::DATA_W-1:0] rdata
);

    logic signed [ile_pkg::DATA_W-1:0] mem [ile_pkg::CAPACITY];
    logic signed [ile_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_req.we)
        begin
            mem[mem_req.waddr] <= mem_req.wdata;
        end
        rdata_reg <= mem[mem_req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ile_seq.sv
// Sequencer: decodes an item and shifts store entries one per cycle.
module ile_seq (
    input  logic                              clk,
    input  logic                              rst_n,
    ile_in_if.sink                            req,
    output logic                              res_valid,
    input  logic                              res_ready,
    output ile_pkg::result_t                  res,
    output ile_pkg::mem_req_t                 mem_req,
    input  logic signed [ile_pkg::DATA_W-1:0] mem_rdata
);

    ile_pkg::state_t                   state_reg, state_next;
    logic [ile_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [ile_pkg::ADDR_W-1:0]        idx_reg, idx_next;
    logic [ile_pkg::ADDR_W-1:0]        pos_reg, pos_next;
    logic signed [ile_pkg::DATA_W-1:0] val_reg, val_next;
    logic signed [ile_pkg::DATA_W-1:0] rvalue_reg, rvalue_next;
    ile_pkg::status_t                  status_reg, status_next;
    logic [ile_pkg::CNT_W-1:0]         ins_pos;
    logic [ile_pkg::CNT_W-1:0]         pos_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ile_pkg::S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rvalue_reg <= rvalue_next;
        status_reg <= status_next;
    end

    assign pos_ext = ile_pkg::CNT_W'(req.position);

    always_comb
    begin
        case (req.action)
            ile_pkg::ACT_PUSH_FRONT: ins_pos = '0;
            ile_pkg::ACT_APPEND:     ins_pos = count_reg;
            default:                 ins_pos = pos_ext;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        val_next      = val_reg;
        rvalue_next   = rvalue_reg;
        status_next   = status_reg;
        mem_req.we    = 1'b0;
        mem_req.waddr = idx_reg;
        mem_req.wdata = mem_rdata;
        mem_req.raddr = idx_reg;
        req.ready     = (state_reg == ile_pkg::S_IDLE);

        case (state_reg)
            ile_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    rvalue_next = '0;
                    status_next = ile_pkg::ST_DONE;
                    val_next    = req.value_in;
                    state_next  = ile_pkg::S_FINISH;
                    case (req.action)
                        ile_pkg::ACT_READ:
                        begin
                            if (pos_ext < count_reg)
                            begin
                                mem_req.raddr = req.position[ile_pkg::ADDR_W-1:0];
                                state_next    = ile_pkg::S_READ;
                            end
                            else
                            begin
                                status_next = ile_pkg::ST_RANGE;
                            end
                        end
                        ile_pkg::ACT_PUSH_FRONT, ile_pkg::ACT_APPEND, ile_pkg::ACT_INSERT:
                        begin
                            if (ins_pos > count_reg)
                            begin
                                status_next = ile_pkg::ST_RANGE;
                            end
                            else if (count_reg >= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
                            begin
                                status_next = ile_pkg::ST_FULL;
                            end
                            else
                            begin
                                pos_next = ins_pos[ile_pkg::ADDR_W-1:0];
                                if (ins_pos == count_reg)
                                begin
                                    state_next = ile_pkg::S_PLACE;
                                end
                                else
                                begin
                                    mem_req.raddr = ile_pkg::ADDR_W'(count_reg - 1'b1);
                                    idx_next      = count_reg[ile_pkg::ADDR_W-1:0];
                                    state_next    = ile_pkg::S_SHIFT_UP;
                                end
                            end
                        end
                        ile_pkg::ACT_DELETE:
                        begin
                            if (pos_ext >= count_reg)
                            begin
                                status_next = ile_pkg::ST_RANGE;
                            end
                            else if (pos_ext + 1'b1 == count_reg)
                            begin
                                count_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                mem_req.raddr = ile_pkg::ADDR_W'(pos_ext + 1'b1);
                                idx_next      = req.position[ile_pkg::ADDR_W-1:0];
                                state_next    = ile_pkg::S_SHIFT_DN;
                            end
                        end
                        default:
                        begin
                            status_next = ile_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ile_pkg::S_READ:
            begin
                rvalue_next = mem_rdata;
                state_next  = ile_pkg::S_FINISH;
            end
            ile_pkg::S_SHIFT_UP:
            begin
                // entry idx-1 arrives now; fetch idx-2 for the next step
                mem_req.we    = 1'b1;
                mem_req.raddr = idx_reg - ile_pkg::ADDR_W'(2);
                if (idx_reg - 1'b1 == pos_reg)
                begin
                    state_next = ile_pkg::S_PLACE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            ile_pkg::S_PLACE:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = pos_reg;
                mem_req.wdata = val_reg;
                count_next    = count_reg + 1'b1;
                state_next    = ile_pkg::S_FINISH;
            end
            ile_pkg::S_SHIFT_DN:
            begin
                mem_req.we    = 1'b1;
                mem_req.raddr = idx_reg + ile_pkg::ADDR_W'(2);
                if (ile_pkg::CNT_W'(idx_reg) + ile_pkg::CNT_W'(2) == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = ile_pkg::S_FINISH;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ile_pkg::S_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ile_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ile_pkg::S_IDLE;
            end
        endcase
    end

    assign res_valid       = (state_reg == ile_pkg::S_FINISH);
    assign res.read_value  = rvalue_reg;
    assign res.status      = status_reg;
    assign res.entry_count = count_reg;

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ile_pkg::CNT_W'(ile_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1
                  || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count moved by more than one");

    a_up_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ile_pkg::S_SHIFT_UP |-> idx_reg > pos_reg)
        else $error("upward shift passed the insert position");

    a_dn_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ile_pkg::S_SHIFT_DN
        |-> ile_pkg::CNT_W'(idx_reg) + ile_pkg::CNT_W'(2) <= count_reg)
        else $error("downward shift ran past the list end");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ile_pkg::S_IDLE || state_reg == ile_pkg::S_FINISH) |-> !mem_req.we)
        else $error("store written outside a shift or place step");

endmodule

### rtl/indexed_list_engine_unit.sv
// A read fetches the entry, then registers it; an insert at p shifts entries p..c-1 up, then places the value;
// a delete shifts the entries above p down. A new item is taken only in the idle state, so one item is
// through the sequencer before the next is accepted; the single store port moves one entry per cycle during a shift.
// A result waits in the output register while the next item is accepted.
// Reset clears the entry count, sequencer state and output valid; store contents
// stay undefined and no stored value is used before it is written, so there is no clearing pass.
module indexed_list_engine_unit (
    input  logic     clk,
    input  logic     rst_n,
    ile_in_if.sink   req,
    ile_out_if.source rsp
);

    ile_pkg::mem_req_t                 mem_req;
    logic signed [ile_pkg::DATA_W-1:0] mem_rdata;
    ile_pkg::result_t                  res;
    logic                              res_valid;
    logic                              res_ready;

    logic                              out_valid_reg;
    ile_pkg::result_t                  out_data_reg;

    ile_store u_store (
        .clk     (clk),
        .mem_req (mem_req),
        .rdata   (mem_rdata)
    );

    ile_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata)
    );

    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_value  = out_data_reg.read_value;
    assign rsp.status      = out_data_reg.status;
    assign rsp.entry_count = out_data_reg.entry_count;

endmodule

### test/tb.sv
// Testbench for the indexed list engine: directed and random list actions, predicted and checked per item.
`timescale 1ns / 1ps

module tb;
    import ile_pkg::*;

    localparam int N_ITEMS     = 1350;
    localparam int CALM_TAIL   = 120;
    localparam int LONG_AT     = 300;
    localparam int LONG_CYCLES = 600;
    localparam int TAIL_CYCLES = 80;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;
    localparam logic [POS_W-1:0]    POS_MAX       = 7'd127;

    typedef struct {
        logic [ACTION_W-1:0]      action;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value_in;
        bit                       sync;
    } list_req_t;

    logic clk;
    logic rst_n;

    ile_in_if  req_if ();
    ile_out_if rsp_if ();

    indexed_list_engine_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    list_req_t pend_q[$];
    result_t   exp_q[$];

    logic signed [DATA_W-1:0] lst_mem [CAPACITY];
    int lst_cnt;

    int  n_total;
    int  n_acc;
    int  n_rsp;
    int  n_err;
    int  g_cnt;
    bit  in_fire;
    int  snd_gap;
    int  rcv_gap;
    int  rcv_hold;
    bit  long_done;
    logic nv;
    logic nr;
    result_t want;

    wire calm    = (n_acc + CALM_TAIL >= n_total);
    wire idle_on = (((n_acc / 150) % 3) != 2);

    function automatic result_t list_apply(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                           logic signed [DATA_W-1:0] v);
        result_t r;
        int p;
        r.read_value  = '0;
        r.status      = ST_DONE;
        case (act)
            ACT_READ:
                if (pos < lst_cnt)
                    r.read_value = lst_mem[pos];
                else
                    r.status = ST_RANGE;
            ACT_PUSH_FRONT, ACT_APPEND, ACT_INSERT:
            begin
                if (act == ACT_PUSH_FRONT)
                    p = 0;
                else if (act == ACT_APPEND)
                    p = lst_cnt;
                else
                    p = pos;
                if (p > lst_cnt)
                    r.status = ST_RANGE;
                else if (lst_cnt >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int k = lst_cnt; k > p; k--)
                        lst_mem[k] = lst_mem[k-1];
                    lst_mem[p] = v;
                    lst_cnt++;
                end
            end
            ACT_DELETE:
                if (pos >= lst_cnt)
                    r.status = ST_RANGE;
                else
                begin
                    for (int k = pos; k + 1 < lst_cnt; k++)
                        lst_mem[k] = lst_mem[k+1];
                    lst_cnt--;
                end
            default: ;
        endcase
        r.entry_count = lst_cnt[CNT_W-1:0];
        return r;
    endfunction

    // tracks only the count, so positions can be aimed at the live list
    task automatic queue_item(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                              logic signed [DATA_W-1:0] v, bit sync);
        list_req_t it;
        int p;
        it.action   = act;
        it.position = pos;
        it.value_in = v;
        it.sync     = sync;
        pend_q.push_back(it);
        if (act == ACT_PUSH_FRONT || act == ACT_APPEND || act == ACT_INSERT)
        begin
            p = (act == ACT_PUSH_FRONT) ? 0 : (act == ACT_APPEND) ? g_cnt : int'(pos);
            if (p <= g_cnt && g_cnt < CAPACITY)
                g_cnt++;
        end
        else if (act == ACT_DELETE && pos < g_cnt)
            g_cnt--;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2:       return -1;
            3:       return 0;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        req_if.valid    = 1'b0;
        req_if.action   = '0;
        req_if.position = '0;
        req_if.value_in = '0;
        rsp_if.ready    = 1'b0;
    end

    always @(posedge clk)
    begin
        in_fire = rst_n && req_if.valid && req_if.ready;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            n_rsp++;
            if (exp_q.size() == 0)
            begin
                $error("result item with nothing expected");
                n_err++;
            end
            else
            begin
                want = exp_q.pop_front();
                if (rsp_if.read_value !== want.read_value)
                begin
                    $error("read_value expected %0d got %0d", want.read_value,
                           rsp_if.read_value);
                    n_err++;
                end
                if (rsp_if.status !== want.status)
                begin
                    $error("status expected %0d got %0d", want.status, rsp_if.status);
                    n_err++;
                end
                if (rsp_if.entry_count !== want.entry_count)
                begin
                    $error("entry_count expected %0d got %0d", want.entry_count,
                           rsp_if.entry_count);
                    n_err++;
                end
            end
        end
        if (in_fire)
        begin
            exp_q.push_back(list_apply(req_if.action, req_if.position, req_if.value_in));
            n_acc++;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            nv = req_if.valid;
            if (in_fire)
            begin
                void'(pend_q.pop_front());
                nv = 1'b0;
                if (!calm && idle_on && $urandom_range(0, 4) == 0)
                    snd_gap = $urandom_range(1, 18);
            end
            if (!nv)
            begin
                if (snd_gap > 0)
                    snd_gap--;
                else if (pend_q.size() > 0 && !(pend_q[0].sync && exp_q.size() != 0))
                begin
                    nv = 1'b1;
                    req_if.action   <= pend_q[0].action;
                    req_if.position <= pend_q[0].position;
                    req_if.value_in <= pend_q[0].value_in;
                end
            end
            req_if.valid <= nv;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            nr = 1'b1;
            if (!long_done && n_rsp >= LONG_AT)
            begin
                long_done = 1'b1;
                rcv_hold  = LONG_CYCLES;
            end
            if (rcv_hold > 0)
            begin
                rcv_hold--;
                nr = 1'b0;
            end
            else if (rcv_gap > 0)
            begin
                rcv_gap--;
                nr = 1'b0;
            end
            else if (!calm && idle_on && $urandom_range(0, 7) == 0)
            begin
                rcv_gap = $urandom_range(1, 18) - 1;
                nr = 1'b0;
            end
            rsp_if.ready <= nr;
        end
    end

    initial
    begin
        bit grow;
        int r;
        int hi;
        logic [ACTION_W-1:0] act;
        logic [POS_W-1:0] pos;

        rst_n    = 1'b0;
        lst_cnt  = 0;
        g_cnt    = 0;
        n_acc    = 0;
        n_rsp    = 0;
        n_err    = 0;
        snd_gap  = 0;
        rcv_gap  = 0;
        rcv_hold = 0;
        n_total  = N_ITEMS;

        queue_item(ACT_READ, 7'd0, 0, 1'b0);
        queue_item(ACT_DELETE, 7'd0, 0, 1'b0);
        queue_item(ACT_INSERT, 7'd1, 5, 1'b0);
        queue_item(ACT_INSERT, 7'd0, 32'sh1234_5678, 1'b0);
        queue_item(ACT_PUSH_FRONT, 7'd0, 32'sh8000_0000, 1'b0);
        queue_item(ACT_APPEND, 7'd0, 32'sh7FFF_FFFF, 1'b0);
        queue_item(ACT_INSERT, 7'd1, -1, 1'b0);
        queue_item(ACT_INSERT, 7'd4, 0, 1'b0);
        queue_item(ACT_INSERT, 7'd6, 9, 1'b0);
        queue_item(ACT_READ, 7'd0, 0, 1'b0);
        queue_item(ACT_READ, 7'd4, 0, 1'b0);
        queue_item(ACT_READ, 7'd5, 0, 1'b0);
        queue_item(ACT_READ, POS_MAX, 0, 1'b0);
        queue_item(ACT_READ, 7'd64, 0, 1'b0);
        queue_item(ACT_DELETE, POS_MAX, 0, 1'b0);
        queue_item(ACT_DELETE, 7'd4, 0, 1'b0);
        queue_item(ACT_DELETE, 7'd0, 0, 1'b0);
        queue_item(ACT_DELETE, 7'd1, 0, 1'b0);
        queue_item(ACT_UNUSED_LO, 7'd3, 32'sh5A5A_A5A5, 1'b0);
        queue_item(ACT_UNUSED_HI, POS_MAX, -1, 1'b0);
        queue_item(ACT_INSERT, POS_MAX, $urandom, 1'b0);
        queue_item(ACT_READ, 7'd0, 0, 1'b0);

        grow = 1'b1;
        while (pend_q.size() < N_ITEMS)
        begin
            if (g_cnt == 0)
                grow = 1'b1;
            else if (g_cnt == CAPACITY && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 4)
                act = ACT_UNUSED_LO + ACTION_W'($urandom_range(0, 2));
            else if (r < 20)
                act = ACT_READ;
            else if (r < (grow ? 80 : 45))
                act = action_t'($urandom_range(ACT_PUSH_FRONT, ACT_INSERT));
            else
                act = ACT_DELETE;
            if (act == ACT_INSERT)
                hi = g_cnt;
            else
                hi = (g_cnt == 0) ? 0 : g_cnt - 1;
            if ($urandom_range(0, 99) < 12)
                pos = POS_W'($urandom_range(0, POS_MAX));
            else
                pos = POS_W'($urandom_range(0, hi));
            queue_item(act, pos, pick_value(), pend_q.size() == 22 || pend_q.size() == 700);
        end
        n_total = pend_q.size();

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        wait (n_acc == n_total);
        wait (exp_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/ile_pkg.sv
rtl/ile_if.sv
rtl/ile_store.sv
rtl/ile_seq.sv
rtl/indexed_list_engine_unit.sv
test/tb.sv
